### hw/rtl/oahs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_pkg
// Shared types and constants of the open-addressing hash set core.
// ----------------------------------------------------------------------------
package oahs_pkg;

    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int CNT_W  = 11;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_CONTAINS = 2'd1,
        KIND_ERASE    = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    localparam logic CFG_MAX_LOAD = 1'b0;
    localparam logic CFG_MIN_LOAD = 1'b1;

    typedef struct packed {
        logic              used;
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
    } entry_t;

endpackage
`default_nettype wire

### hw/rtl/oahs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oahs_ram
// Generic simple dual-port RAM, one write and one registered read port,
// read returns the old data on a same-address write.
// ----------------------------------------------------------------------------
module oahs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/open_addressing_hash_set_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_set_core
// Hash set of keys with stored hashes, triangular probing, grow and shrink
// by rehash through a scratch memory.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser
// s_      | in  | key [31:0], key_hash [63:32]            | kind [1:0]
// m_      | out | ok [0], item_count [11:1], capacity [22:12] | -
// cfg_    | in  | index 0 max_load_q8, 1 min_load_q8      | -
//
// one request at a time; a lookup scans all cap slots through the single read
// port of the table memory.
// a resize copies the old_cap entries to the scratch memory, clearing the table,
// then reinserts each used key with a full probe.
// clear sweeps cap entries; after reset a sweep of all MAX_CAPACITY entries runs
// before the first transfer is taken. results wait in an output register.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_core #(
    parameter int INITIAL_CAPACITY = 16,
    parameter int MAX_CAPACITY     = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key, key_hash
    input  wire logic [1:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // ok, item_count, table_capacity, pad
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);
    import oahs_pkg::*;

    localparam int AW = $clog2(MAX_CAPACITY);
    localparam int CW = AW + 1;
    localparam int LW = CW + 9;

    typedef enum logic [7:0] {
        S_CLR    = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_PROBE  = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_COPY   = 8'b0001_0000,
        S_RELOAD = 8'b0010_0000,
        S_RWAIT  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [8:0] max_load_reg;
    logic [7:0] min_load_reg;
    logic [CW-1:0] cap_reg, cap_next, count_reg, count_next, old_cap_reg, old_cap_next;
    logic [CW-1:0] idx_reg, idx_next, step_reg, step_next, lim_reg, lim_next;
    logic [AW-1:0] slot_reg, slot_next, rd_slot_reg, rd_slot_next;
    logic [AW-1:0] found_slot_reg, found_slot_next, empty_slot_reg, empty_slot_next;
    logic [AW-1:0] cp_idx_reg, cp_idx_next;
    logic rd_v_reg, rd_v_next, found_reg, found_next, empty_v_reg, empty_v_next;
    logic cp_v_reg, cp_v_next, rehash_reg, rehash_next, init_reg, init_next;
    logic ok_reg, ok_next;
    kind_t kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg, m_data_next;

    logic main_we, scr_we;
    logic [AW-1:0] main_waddr, main_raddr, scr_raddr;
    entry_t main_wdata, main_rdata, scr_rdata;
    logic [AW-1:0] mask;
    logic [CW-1:0] cnt_inc, cnt_dec, half_cap;
    logic grow, shrink;

    oahs_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CAPACITY)) u_table (
        .aclk(aclk), .we(main_we), .waddr(main_waddr), .wdata(main_wdata),
        .raddr(main_raddr), .rdata(main_rdata)
    );

    oahs_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CAPACITY)) u_scratch (
        .aclk(aclk), .we(scr_we), .waddr(cp_idx_reg), .wdata(main_rdata),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );

    assign mask     = AW'(cap_reg - CW'(1));
    assign cnt_inc  = count_reg + CW'(1);
    assign cnt_dec  = count_reg - CW'(1);
    assign half_cap = cap_reg >> 1;
    assign grow   = (LW'({cnt_inc, 8'h00}) >= LW'(max_load_reg) * LW'(cap_reg))
                    && (cap_reg != CW'(MAX_CAPACITY));
    assign shrink = (LW'({cnt_dec, 8'h00}) <= LW'(min_load_reg) * LW'(cap_reg))
                    && (half_cap != '0) && (half_cap >= cnt_dec);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        cap_next = cap_reg; count_next = count_reg; old_cap_next = old_cap_reg;
        idx_next = idx_reg; step_next = step_reg; lim_next = lim_reg;
        slot_next = slot_reg; rd_slot_next = rd_slot_reg;
        found_slot_next = found_slot_reg; empty_slot_next = empty_slot_reg;
        cp_idx_next = cp_idx_reg; rd_v_next = 1'b0; cp_v_next = 1'b0;
        found_next = found_reg; empty_v_next = empty_v_reg;
        rehash_next = rehash_reg; init_next = init_reg; ok_next = ok_reg;
        kind_next = kind_reg; key_next = key_reg; hash_next = hash_reg;
        m_valid_next = m_valid_reg; m_data_next = m_data_reg;
        main_we = 1'b0; main_waddr = idx_reg[AW-1:0]; main_wdata = '0;
        main_raddr = slot_reg; scr_we = 1'b0; scr_raddr = idx_reg[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                if (idx_reg == lim_reg) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        count_next = '0;
                        ok_next    = 1'b1;
                        state_next = S_OUT;
                    end
                end else begin
                    main_we  = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = kind_t'(s_tuser);
                    key_next    = s_tdata[31:0];
                    hash_next   = s_tdata[63:32];
                    rehash_next = 1'b0;
                    if (kind_t'(s_tuser) == KIND_CLEAR) begin
                        idx_next   = '0;
                        lim_next   = cap_reg;
                        state_next = S_CLR;
                    end else begin
                        slot_next    = s_tdata[32 +: AW] & mask;
                        step_next    = '0;
                        found_next   = 1'b0;
                        empty_v_next = 1'b0;
                        state_next   = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (step_reg != cap_reg) begin
                    rd_v_next    = 1'b1;
                    rd_slot_next = slot_reg;
                    slot_next    = (slot_reg + AW'(step_reg + CW'(1))) & mask;
                    step_next    = step_reg + CW'(1);
                end
                if (rd_v_reg) begin
                    if (main_rdata.used && main_rdata.key == key_reg && !found_reg) begin
                        found_next      = 1'b1;
                        found_slot_next = rd_slot_reg;
                    end
                    if (!main_rdata.used && !empty_v_reg) begin
                        empty_v_next    = 1'b1;
                        empty_slot_next = rd_slot_reg;
                    end
                end else if (step_reg == cap_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_OUT;
                if (rehash_reg) begin
                    main_we    = 1'b1;
                    main_waddr = empty_slot_reg;
                    main_wdata = '{used: 1'b1, hash: hash_reg, key: key_reg};
                    count_next = cnt_inc;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RELOAD;
                end else begin
                    ok_next = 1'b0;
                    priority if (kind_reg == KIND_INSERT) begin
                        if (!found_reg && empty_v_reg) begin
                            main_we    = 1'b1;
                            main_waddr = empty_slot_reg;
                            main_wdata = '{used: 1'b1, hash: hash_reg, key: key_reg};
                            count_next = cnt_inc;
                            ok_next    = 1'b1;
                            if (grow) begin
                                cap_next = {cap_reg[CW-2:0], 1'b0};
                            end
                        end
                    end else if (kind_reg == KIND_CONTAINS) begin
                        ok_next = found_reg;
                    end else begin
                        if (found_reg) begin
                            main_we    = 1'b1;
                            main_waddr = found_slot_reg;
                            count_next = cnt_dec;
                            ok_next    = 1'b1;
                            if (shrink) begin
                                cap_next = half_cap;
                            end
                        end
                    end
                    if (cap_next != cap_reg) begin
                        old_cap_next = cap_reg;
                        count_next   = '0;
                        idx_next     = '0;
                        rehash_next  = 1'b1;
                        state_next   = S_COPY;
                    end
                end
            end
            S_COPY: begin
                // read-first table: old entry comes back while it is cleared
                main_raddr = idx_reg[AW-1:0];
                if (idx_reg != old_cap_reg) begin
                    main_we     = 1'b1;
                    cp_v_next   = 1'b1;
                    cp_idx_next = idx_reg[AW-1:0];
                    idx_next    = idx_reg + CW'(1);
                end
                scr_we = cp_v_reg;
                if (!cp_v_reg && idx_reg == old_cap_reg) begin
                    idx_next   = '0;
                    state_next = S_RELOAD;
                end
            end
            S_RELOAD: begin
                if (idx_reg == old_cap_reg) begin
                    rehash_next = 1'b0;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (scr_rdata.used) begin
                    key_next     = scr_rdata.key;
                    hash_next    = scr_rdata.hash;
                    slot_next    = scr_rdata.hash[AW-1:0] & mask;
                    step_next    = '0;
                    found_next   = 1'b0;
                    empty_v_next = 1'b0;
                    state_next   = S_PROBE;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RELOAD;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, 11'(cap_reg), 11'(count_reg), ok_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            init_reg     <= 1'b1;
            idx_reg      <= '0;
            lim_reg      <= CW'(MAX_CAPACITY);
            cap_reg      <= CW'(INITIAL_CAPACITY);
            count_reg    <= '0;
            max_load_reg <= 9'd192;
            min_load_reg <= 8'd64;
            m_valid_reg  <= 1'b0;
            rd_v_reg     <= 1'b0;
            cp_v_reg     <= 1'b0;
            rehash_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            idx_reg     <= idx_next;
            lim_reg     <= lim_next;
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            rd_v_reg    <= rd_v_next;
            cp_v_reg    <= cp_v_next;
            rehash_reg  <= rehash_next;
            if (cfg_wr_en && cfg_index == CFG_MAX_LOAD) begin
                max_load_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == CFG_MIN_LOAD) begin
                min_load_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        old_cap_reg    <= old_cap_next;
        step_reg       <= step_next;
        slot_reg       <= slot_next;
        rd_slot_reg    <= rd_slot_next;
        found_slot_reg <= found_slot_next;
        empty_slot_reg <= empty_slot_next;
        cp_idx_reg     <= cp_idx_next;
        found_reg      <= found_next;
        empty_v_reg    <= empty_v_next;
        ok_reg         <= ok_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        m_data_reg     <= m_data_next;
    end

    a_count_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg) else $error("item count above capacity");
    a_cap_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(cap_reg)) else $error("capacity not a power of two");
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("took two requests");
    a_rehash_path: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_COPY |-> rehash_reg) else $error("copy outside rehash");

endmodule
`default_nettype wire
